/* rtl/core/nbv_pkg.sv */
// Shared types, codes and constants for the neighbour colour vote block.
// Used by nbv_cell, nbv_rem and neighbor_color_vote; depends on nothing.
`default_nettype none

package nbv_pkg;

  typedef logic [7:0] color_t;

  // Default sizing
  localparam int SET_DEPTH_DEF  = 32;
  localparam int TICK_WIDTH_DEF = 32;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_DISTANCE_LIMIT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_UPDATE_PERIOD   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRANSMIT_PERIOD = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_COLOR   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_UPDATE_PHASE    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRANSMIT_PHASE  = 3'd5;

  // Register reset values
  localparam logic [7:0]  RST_DISTANCE_LIMIT  = 8'd100;
  localparam logic [15:0] RST_UPDATE_PERIOD   = 16'd64;
  localparam logic [15:0] RST_TRANSMIT_PERIOD = 16'd16;
  localparam color_t      RST_INITIAL_COLOR   = 8'd0;
  localparam logic [5:0]  RST_UPDATE_PHASE    = 6'd0;
  localparam logic [5:0]  RST_TRANSMIT_PHASE  = 6'd0;

  // Action codes of an input word
  localparam logic [1:0] ACT_RECEIVE = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_POLL    = 2'd2;

  // Remainder unit: one quotient bit per cycle over the random byte
  localparam int REM_STEPS = 8;
  localparam logic [2:0] REM_LAST = 3'(REM_STEPS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_INSERT,
    ST_TICK,
    ST_DIV,
    ST_PICK,
    ST_DONE
  } state_t;

  // Control handed to every cell of the set chain
  typedef struct packed {
    logic   shift;
    color_t probe;
  } cell_ctrl_t;

  // LED code: (colour mod 63) + 1, as 2-bit red, green, blue fields.
  // 64 is 1 mod 63, so fold the top two bits onto the low six.
  function automatic logic [5:0] rgb_code(input color_t color);
    logic [6:0] folded;
    logic [5:0] residue;
    folded  = 7'(color[7:6]) + 7'(color[5:0]);
    residue = (folded >= 7'd63) ? 6'(folded - 7'd63) : folded[5:0];
    return residue + 6'd1;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/nbv_cell.sv */
// One cell of the colour set chain: holds an entry, passes it to its neighbour
// on insert, and answers the duplicate probe and the pick. Uses nbv_pkg.
`default_nettype none

module nbv_cell #(
  parameter int CW    = 6,
  parameter int IW    = 5,
  parameter int INDEX = 0
) (
  input  wire                 clk,
  input  nbv_pkg::cell_ctrl_t ctrl,
  input  nbv_pkg::color_t     shift_in,
  input  wire  [CW-1:0]       count,
  input  wire  [IW-1:0]       pick,
  output nbv_pkg::color_t     value,
  output logic                hit,
  output nbv_pkg::color_t     pick_val
);
  import nbv_pkg::*;

  localparam logic [CW-1:0] POS   = CW'(INDEX);
  localparam logic [IW-1:0] SLOT  = IW'(INDEX);

  logic live;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= shift_in;
    end
  end

  assign live     = POS < count;
  assign hit      = live && (value == ctrl.probe);
  assign pick_val = (pick == SLOT) ? value : '0;

endmodule

`default_nettype wire

/* rtl/core/nbv_rem.sv */
// Restoring remainder unit: random byte modulo the set size, one bit a cycle.
// Uses nbv_pkg for the step count.
`default_nettype none

module nbv_rem #(
  parameter int CW = 6
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  nbv_pkg::color_t    dividend,
  input  wire  [CW-1:0]      divisor,
  output logic               done,
  output logic [CW-1:0]      rem
);
  import nbv_pkg::*;

  logic          busy;
  logic [2:0]    step;
  color_t        dvd;
  logic [CW:0]   trial;
  logic [CW-1:0] rem_next;

  // Shift in the next dividend bit, subtract where it fits
  always_comb begin
    trial    = {rem, dvd[7]};
    rem_next = (trial >= {1'b0, divisor}) ? CW'(trial - {1'b0, divisor}) : trial[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= '0;
        dvd  <= dividend;
      end else if (busy) begin
        rem  <= rem_next;
        dvd  <= {dvd[6:0], 1'b0};
        step <= step + 3'd1;
        if (step == REM_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/neighbor_color_vote.sv */
// Neighbour colour vote: top level with control sequencer, timers and output word.
// Depends on nbv_pkg, nbv_cell and nbv_rem.
//
// Usage: one input word per handshake (in_valid high, in_stall low) carries an
// action: receive (colour and distance), tick (random byte) or transmit poll.
// Each word gives exactly one output word on out_valid/out_stall, holding the
// grant flag, current colour, adoption flag, LED levels, set size and overflow.
// The distinct colours live in a chain of SET_DEPTH cells; a new colour enters
// the first cell and every held colour moves one cell on. The duplicate check
// probes all cells at once.
// Steps per word: receive runs exec, insert, done; poll and action three run exec,
// done; tick runs exec, tick, done, and an adopting tick adds the remainder unit,
// which reduces the random byte by the set size, and pick. One word is in flight
// at a time; in_stall is low only while the sequencer is idle. A finished word
// waits in the output register while the next input word is taken; when out_stall
// holds, the sequencer waits at its last step. Reset (rst, synchronous) returns
// the registers to their defaults, clears the set and tick counter and loads colour
// and marks from the defaults. The configuration port writes one register per
// cycle with cfg_we; the user must write only while idle, unenforced by the block.
`default_nettype none

module neighbor_color_vote #(
  parameter int SET_DEPTH  = nbv_pkg::SET_DEPTH_DEF,
  parameter int TICK_WIDTH = nbv_pkg::TICK_WIDTH_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire  [nbv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire  [nbv_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [1:0]                      action,
  input  wire  [7:0]                      rx_color,
  input  wire  [7:0]                      rx_distance,
  input  wire  [7:0]                      random_value,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic                            message_valid,
  output logic [7:0]                      message_color,
  output logic                            color_changed,
  output logic [1:0]                      red_level,
  output logic [1:0]                      green_level,
  output logic [1:0]                      blue_level,
  output logic [5:0]                      set_count,
  output logic                            set_overflow
);
  import nbv_pkg::*;

  localparam int CW = $clog2(SET_DEPTH + 1);
  localparam int IW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int EW = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;
  localparam logic [CW-1:0] DEPTH_C = CW'(SET_DEPTH);

  // Configuration registers
  logic [7:0]  distance_limit;
  logic [15:0] update_period;
  logic [15:0] transmit_period;

  // Block state
  state_t                state, state_next;
  color_t                current_color;
  logic [CW-1:0]         count;
  logic [TICK_WIDTH-1:0] tick;
  logic [TICK_WIDTH-1:0] update_mark;
  logic [TICK_WIDTH-1:0] transmit_mark;

  // Latched input word and per-word flags
  logic [1:0] op;
  color_t     rx_col;
  color_t     rx_dist;
  color_t     rnd;
  logic       in_range;
  logic       match;
  logic       flag_valid;
  logic       flag_changed;
  logic       flag_ovf;
  logic [IW-1:0] sel_pos;

  // Sequencer strobes
  logic shift_en;
  logic div_start;
  logic load_out;

  // Timers
  logic [TICK_WIDTH-1:0] upd_diff;
  logic [TICK_WIDTH-1:0] tx_diff;
  logic                  upd_elapsed;
  logic                  tx_elapsed;

  // Cell chain
  cell_ctrl_t cell_ctrl;
  color_t     cell_val  [SET_DEPTH];
  color_t     cell_pick [SET_DEPTH];
  logic [SET_DEPTH-1:0] hit_vec;
  logic       hit_any;
  color_t     pick_any;

  // Remainder unit
  logic          div_done;
  logic [CW-1:0] div_rem;
  logic [CW-1:0] pos_full;

  logic [CW+5:0] count_ext;
  logic [5:0]    rgb;

  assign upd_diff    = tick - update_mark;
  assign tx_diff     = tick - transmit_mark;
  assign upd_elapsed = EW'(upd_diff) > EW'(update_period);
  assign tx_elapsed  = EW'(tx_diff) > EW'(transmit_period);

  assign cell_ctrl.shift = shift_en;
  assign cell_ctrl.probe = rx_col;

  genvar gi;
  generate
    for (gi = 0; gi < SET_DEPTH; gi++) begin : g_cell
      color_t chain_in;
      if (gi == 0) begin : g_head
        assign chain_in = rx_col;
      end else begin : g_link
        assign chain_in = cell_val[gi-1];
      end
      nbv_cell #(
        .CW    (CW),
        .IW    (IW),
        .INDEX (gi)
      ) u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .shift_in (chain_in),
        .count    (count),
        .pick     (sel_pos),
        .value    (cell_val[gi]),
        .hit      (hit_vec[gi]),
        .pick_val (cell_pick[gi])
      );
    end
  endgenerate

  always_comb begin
    hit_any  = |hit_vec;
    pick_any = '0;
    for (int i = 0; i < SET_DEPTH; i++) begin
      pick_any = pick_any | cell_pick[i];
    end
  end

  nbv_rem #(
    .CW (CW)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rnd),
    .divisor  (count),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Oldest colour sits deepest in the chain
  assign pos_full = count - CW'(1) - div_rem;

  assign count_ext = {6'd0, count};
  assign rgb       = rgb_code(current_color);
  assign in_stall  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    shift_en   = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (op)
          ACT_RECEIVE: state_next = ST_INSERT;
          ACT_TICK:    state_next = ST_TICK;
          default:     state_next = ST_DONE;
        endcase
      end
      ST_INSERT: begin
        if (in_range && !match && (count < DEPTH_C)) begin
          shift_en = 1'b1;
        end
        state_next = ST_DONE;
      end
      ST_TICK: begin
        if (upd_elapsed && (count != '0)) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_limit  <= RST_DISTANCE_LIMIT;
      update_period   <= RST_UPDATE_PERIOD;
      transmit_period <= RST_TRANSMIT_PERIOD;
      current_color   <= RST_INITIAL_COLOR;
      update_mark     <= TICK_WIDTH'(RST_UPDATE_PHASE);
      transmit_mark   <= TICK_WIDTH'(RST_TRANSMIT_PHASE);
      count           <= '0;
      tick            <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DISTANCE_LIMIT:  distance_limit  <= cfg_data[7:0];
          CFG_UPDATE_PERIOD:   update_period   <= cfg_data;
          CFG_TRANSMIT_PERIOD: transmit_period <= cfg_data;
          CFG_INITIAL_COLOR:   current_color   <= cfg_data[7:0];
          CFG_UPDATE_PHASE:    update_mark     <= TICK_WIDTH'(cfg_data[5:0]);
          CFG_TRANSMIT_PHASE:  transmit_mark   <= TICK_WIDTH'(cfg_data[5:0]);
          default: ;
        endcase
      end

      if (state == ST_IDLE && in_valid) begin
        op           <= action;
        rx_col       <= rx_color;
        rx_dist      <= rx_distance;
        rnd          <= random_value;
        flag_valid   <= 1'b0;
        flag_changed <= 1'b0;
        flag_ovf     <= 1'b0;
      end

      case (state)
        ST_EXEC: begin
          in_range <= (rx_dist <= distance_limit);
          match    <= hit_any;
          if (op == ACT_TICK) begin
            tick <= tick + TICK_WIDTH'(1);
          end
          if (op == ACT_POLL && tx_elapsed) begin
            transmit_mark <= tick;
            flag_valid    <= 1'b1;
          end
        end
        ST_INSERT: begin
          if (in_range && !match) begin
            if (count < DEPTH_C) begin
              count <= count + CW'(1);
            end else begin
              flag_ovf <= 1'b1;
            end
          end
        end
        ST_TICK: begin
          if (upd_elapsed) begin
            update_mark <= tick;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            sel_pos <= pos_full[IW-1:0];
          end
        end
        ST_PICK: begin
          current_color <= pick_any;
          count         <= '0;
          flag_changed  <= 1'b1;
        end
        default: ;
      endcase

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output word; payload holds while stalled
  always_ff @(posedge clk) begin
    if (load_out) begin
      message_valid <= flag_valid;
      message_color <= current_color;
      color_changed <= flag_changed;
      red_level     <= rgb[5:4];
      green_level   <= rgb[3:2];
      blue_level    <= rgb[1:0];
      set_count     <= count_ext[5:0];
      set_overflow  <= flag_ovf;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("set count beyond depth");

  a_adopt_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && color_changed) |-> (set_count == 6'd0))
    else $error("adopting word reports a non-empty set");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(message_valid && color_changed) && !(message_valid && set_overflow))
    else $error("output word carries flags of two actions");

  a_rem_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("remainder finished outside its step");

endmodule

`default_nettype wire
